### rtl/core/wavhp_pkg.sv
// wavhp_pkg: constants shared by the WAV header parser.
// Holds the tag words, status codes and stream widths.
// No dependencies.
package wavhp_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned STATUS_W   = 3;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned HALF_W     = 16;
    localparam int unsigned FMT_BYTES  = 16;
    localparam int unsigned FMT_IDX_W  = $clog2(FMT_BYTES);
    localparam int unsigned FMT_W      = FMT_BYTES * BYTE_W;
    localparam int unsigned M_TDATA_W  = 3 * HALF_W + 4 * WORD_W;

    localparam logic [WORD_W-1:0] MIN_FMT_SIZE = WORD_W'(FMT_BYTES);

    // tags as they appear in the shift word, first byte lowest
    localparam logic [WORD_W-1:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [WORD_W-1:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [WORD_W-1:0] TAG_FMT  = 32'h2074_6d66;
    localparam logic [WORD_W-1:0] TAG_DATA = 32'h6174_6164;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_RIFF  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_WAVE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FMT_SMALL = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NO_FMT    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NO_DATA   = 3'd5;

endpackage

### rtl/core/wav_header_parser.sv
// wav_header_parser: byte-serial RIFF/WAVE header parser, top level.
// Depends on wavhp_pkg.
//
// channel | dir | tdata                          | tuser       | tlast
// s_      | in  | data byte                      | first byte  | last byte
// m_      | out | fmt fields, data size, offset  | status      | -
//
// One byte per cycle while no result is stalled; the result request appears in
// the output register the cycle after the byte that ends the parse.
// aresetn (synchronous) returns the parser to waiting for the RIFF tag.
// A stalled result request holds its register; a new byte is taken whenever
// that register is empty or being drained.
module wav_header_parser (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [wavhp_pkg::BYTE_W-1:0]   s_tdata,   // [7:0] data_byte
    input  logic                           s_tuser,   // [0] first_byte
    input  logic                           s_tlast,   // last_byte
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [15:0] channel_count, [47:16] sample_rate, [79:48] bytes_per_second,
    // [95:80] block_align, [111:96] sample_bits, [143:112] data_size,
    // [175:144] data_offset
    output logic [wavhp_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [wavhp_pkg::STATUS_W-1:0] m_tuser    // [2:0] status
);

    localparam logic [3:0] PH_RIFF     = 4'd0;
    localparam logic [3:0] PH_FSIZE    = 4'd1;
    localparam logic [3:0] PH_WAVE     = 4'd2;
    localparam logic [3:0] PH_CID      = 4'd3;
    localparam logic [3:0] PH_SZ_FMT   = 4'd4;
    localparam logic [3:0] PH_SZ_DATA  = 4'd5;
    localparam logic [3:0] PH_SZ_OTHER = 4'd6;
    localparam logic [3:0] PH_FMT      = 4'd7;
    localparam logic [3:0] PH_SKIP     = 4'd8;
    localparam logic [3:0] PH_PAD      = 4'd9;
    localparam logic [3:0] PH_DONE     = 4'd10;

    localparam int unsigned W  = wavhp_pkg::WORD_W;
    localparam int unsigned BW = wavhp_pkg::BYTE_W;

    logic [3:0]                     phase_reg, phase_next;
    logic [W-1:0]                   pos_reg, pos_next;
    logic [W-1:0]                   left_reg, left_next;
    logic [W-1:0]                   tag_reg, tag_next;
    logic [W-1:0]                   chunk_reg, chunk_next;
    logic                           fmt_seen_reg, fmt_seen_next;
    logic [wavhp_pkg::FMT_W-1:0]    held_reg, held_next;
    logic                           m_valid_reg;
    logic [wavhp_pkg::M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic [wavhp_pkg::STATUS_W-1:0] m_user_reg, m_user_next;

    logic                           accept;
    logic                           emit;
    logic [3:0]                     eph;
    logic [W-1:0]                   epos, eleft, etag, echunk;
    logic                           efmt;
    logic [W-1:0]                   tag_in, left_dec, pos_inc, skip_len;
    logic [wavhp_pkg::FMT_IDX_W-1:0] fmt_idx;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    always_comb begin
        // a first byte starts from the cleared state
        eph    = s_tuser ? PH_RIFF : phase_reg;
        epos   = s_tuser ? '0 : pos_reg;
        eleft  = s_tuser ? '0 : left_reg;
        etag   = s_tuser ? '0 : tag_reg;
        echunk = s_tuser ? '0 : chunk_reg;
        efmt   = s_tuser ? 1'b0 : fmt_seen_reg;

        pos_inc  = epos + W'(1);
        left_dec = eleft - W'(1);
        tag_in   = (eph <= PH_SZ_OTHER) ? {s_tdata, etag[W-1:BW]} : etag;
        skip_len = echunk - wavhp_pkg::MIN_FMT_SIZE;
        fmt_idx  = wavhp_pkg::FMT_IDX_W'(0) - eleft[wavhp_pkg::FMT_IDX_W-1:0];

        phase_next    = eph;
        pos_next      = pos_inc;
        left_next     = eleft;
        tag_next      = tag_in;
        chunk_next    = echunk;
        fmt_seen_next = efmt;
        held_next     = held_reg;
        emit          = 1'b0;
        m_user_next   = wavhp_pkg::ST_OK;
        m_data_next   = '0;

        case (eph)
            PH_RIFF: begin
                if (epos == W'(3)) begin
                    if (tag_in != wavhp_pkg::TAG_RIFF) begin
                        emit        = 1'b1;
                        m_user_next = wavhp_pkg::ST_NOT_RIFF;
                    end else begin
                        phase_next = PH_FSIZE;
                    end
                end
            end
            PH_FSIZE: begin
                if (epos == W'(7)) begin
                    phase_next = PH_WAVE;
                end
            end
            PH_WAVE: begin
                if (epos == W'(11)) begin
                    if (tag_in != wavhp_pkg::TAG_WAVE) begin
                        emit        = 1'b1;
                        m_user_next = wavhp_pkg::ST_NOT_WAVE;
                    end else begin
                        phase_next = PH_CID;
                        left_next  = W'(4);
                        tag_next   = '0;
                    end
                end
            end
            PH_CID: begin
                left_next = left_dec;
                if (left_dec == '0) begin
                    left_next = W'(4);
                    if (tag_in == wavhp_pkg::TAG_FMT) begin
                        phase_next = PH_SZ_FMT;
                    end else if (tag_in == wavhp_pkg::TAG_DATA) begin
                        phase_next = PH_SZ_DATA;
                    end else begin
                        phase_next = PH_SZ_OTHER;
                    end
                end
            end
            PH_SZ_FMT, PH_SZ_DATA, PH_SZ_OTHER: begin
                left_next = left_dec;
                if (left_dec == '0) begin
                    chunk_next = tag_in;
                    if (eph == PH_SZ_FMT) begin
                        if (tag_in < wavhp_pkg::MIN_FMT_SIZE) begin
                            emit        = 1'b1;
                            m_user_next = wavhp_pkg::ST_FMT_SMALL;
                        end else begin
                            left_next  = wavhp_pkg::MIN_FMT_SIZE;
                            phase_next = PH_FMT;
                        end
                    end else if (eph == PH_SZ_DATA && efmt) begin
                        emit        = 1'b1;
                        m_user_next = wavhp_pkg::ST_OK;
                        m_data_next = {pos_inc, tag_in, held_reg[127:16]};
                    end else if (tag_in == '0) begin
                        phase_next = PH_CID;
                        left_next  = W'(4);
                        tag_next   = '0;
                    end else begin
                        phase_next = PH_SKIP;
                        left_next  = tag_in;
                    end
                end
            end
            PH_FMT: begin
                for (int i = 0; i < int'(wavhp_pkg::FMT_BYTES); i++) begin
                    if (fmt_idx == wavhp_pkg::FMT_IDX_W'(i)) begin
                        held_next[i*BW +: BW] = s_tdata;
                    end
                end
                left_next = left_dec;
                if (left_dec == '0) begin
                    fmt_seen_next = 1'b1;
                    if (skip_len != '0) begin
                        phase_next = PH_SKIP;
                        left_next  = skip_len;
                    end else if (echunk[0]) begin
                        phase_next = PH_PAD;
                    end else begin
                        phase_next = PH_CID;
                        left_next  = W'(4);
                        tag_next   = '0;
                    end
                end
            end
            PH_SKIP: begin
                left_next = left_dec;
                if (left_dec == '0) begin
                    if (echunk[0]) begin
                        phase_next = PH_PAD;
                    end else begin
                        phase_next = PH_CID;
                        left_next  = W'(4);
                        tag_next   = '0;
                    end
                end
            end
            PH_PAD: begin
                phase_next = PH_CID;
                left_next  = W'(4);
                tag_next   = '0;
            end
            default: begin
                // parse finished: hold everything until a first byte
                phase_next = eph;
                pos_next   = epos;
                tag_next   = etag;
            end
        endcase

        if (eph != PH_DONE && s_tlast && !emit) begin
            emit = 1'b1;
            if (phase_next == PH_RIFF) begin
                m_user_next = wavhp_pkg::ST_NOT_RIFF;
            end else if (phase_next == PH_FSIZE || phase_next == PH_WAVE) begin
                m_user_next = wavhp_pkg::ST_NOT_WAVE;
            end else if (fmt_seen_next) begin
                m_user_next = wavhp_pkg::ST_NO_DATA;
            end else begin
                m_user_next = wavhp_pkg::ST_NO_FMT;
            end
        end
        if (emit) begin
            phase_next = PH_DONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_RIFF;
            pos_reg      <= '0;
            left_reg     <= '0;
            tag_reg      <= '0;
            chunk_reg    <= '0;
            fmt_seen_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg    <= phase_next;
                pos_reg      <= pos_next;
                left_reg     <= left_next;
                tag_reg      <= tag_next;
                chunk_reg    <= chunk_next;
                fmt_seen_reg <= fmt_seen_next;
            end
            if (accept && emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            held_reg <= held_next;
        end
        if (accept && emit) begin
            m_data_reg <= m_data_next;
            m_user_reg <= m_user_next;
        end
    end

endmodule

### test/testbench.sv
// testbench: self-checking bench for the byte-serial WAV header parser.
// Streams good and broken RIFF/WAVE headers under varied flow control and
// checks every result against an in-bench parse model. Needs wavhp_pkg and the RTL.
module testbench;

    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          HOLD_CYCLES    = 200;
    localparam int          SETTLE_CYCLES  = 4;
    localparam logic [31:0] FMT_BODY       = 32'd16;

    // chunk IDs as they build up in the shift word, first byte lowest
    localparam logic [31:0] ID_RIFF = "FFIR";
    localparam logic [31:0] ID_WAVE = "EVAW";
    localparam logic [31:0] ID_FMT  = " tmf";
    localparam logic [31:0] ID_DATA = "atad";
    localparam logic [31:0] ID_LIST = "TSIL";

    typedef enum logic [3:0] {
        P_RIFF, P_FSIZE, P_WAVE, P_CID, P_SZ_FMT, P_SZ_DATA, P_SZ_OTHER,
        P_FMT, P_SKIP, P_PAD, P_DONE
    } parse_phase_e;

    typedef struct {
        logic [wavhp_pkg::STATUS_W-1:0] status;
        logic [15:0]         channels;
        logic [31:0]         rate;
        logic [31:0]         byte_rate;
        logic [15:0]         align;
        logic [15:0]         bits;
        logic [31:0]         data_len;
        logic [31:0]         data_pos;
    } header_t;

    logic                aclk;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    wire                 s_tready;
    logic [7:0]          s_tdata  = 8'h00;   // [7:0] data_byte
    logic                s_tuser  = 1'b0;    // [0] first_byte
    logic                s_tlast  = 1'b0;    // last_byte
    wire                 m_tvalid;
    logic                m_tready = 1'b0;
    // [15:0] channels, [47:16] rate, [79:48] byte rate, [95:80] align,
    // [111:96] bits, [143:112] data size, [175:144] data offset
    wire [175:0]         m_tdata;
    wire [wavhp_pkg::STATUS_W-1:0] m_tuser;  // [2:0] status

    wav_header_parser u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // parse model state
    parse_phase_e phase;
    logic [31:0]  pos_ctr, remaining, shift_word, chunk_len, data_len, data_pos;
    logic [127:0] fmt_body;
    bit           fmt_done;

    header_t      pending_headers[$];
    logic [7:0]   file_bytes[$];

    int errors         = 0;
    int bytes_taken    = 0;
    int files_sent     = 0;
    int results_seen   = 0;
    int status_count[8];
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_requests  = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    int stall_cycles   = 0;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic void clear_parse();
        phase      = P_RIFF;
        pos_ctr    = '0;
        remaining  = '0;
        shift_word = '0;
        chunk_len  = '0;
        data_len   = '0;
        data_pos   = '0;
        fmt_body   = '0;
        fmt_done   = 1'b0;
    endfunction

    function automatic void open_chunk_id();
        phase      = P_CID;
        remaining  = 32'd4;
        shift_word = '0;
    endfunction

    // odd-sized bodies carry one pad byte
    function automatic void end_body();
        if (chunk_len[0]) phase = P_PAD;
        else open_chunk_id();
    endfunction

    function automatic void skip_body(input logic [31:0] n);
        if (n == 0) begin
            end_body();
        end else begin
            remaining = n;
            phase     = P_SKIP;
        end
    endfunction

    function automatic void finish_parse(input logic [wavhp_pkg::STATUS_W-1:0] code,
                                         output header_t r);
        r = '{default: '0};
        r.status = code;
        if (code == wavhp_pkg::ST_OK) begin
            r.channels  = fmt_body[31:16];
            r.rate      = fmt_body[63:32];
            r.byte_rate = fmt_body[95:64];
            r.align     = fmt_body[111:96];
            r.bits      = fmt_body[127:112];
            r.data_len  = data_len;
            r.data_pos  = data_pos;
        end
        phase = P_DONE;
    endfunction

    function automatic bit parse_header_byte(input logic [7:0] b, input bit is_first,
                                             input bit is_last, output header_t r);
        logic [31:0] at;
        logic [3:0]  idx;
        r = '{default: '0};
        if (is_first) clear_parse();
        if (phase == P_DONE) return 1'b0;
        at      = pos_ctr;
        pos_ctr = pos_ctr + 32'd1;
        if (phase <= P_SZ_OTHER) shift_word = {b, shift_word[31:8]};
        case (phase)
            P_RIFF: begin
                if (at == 3) begin
                    if (shift_word != ID_RIFF) begin
                        finish_parse(wavhp_pkg::ST_NOT_RIFF, r);
                        return 1'b1;
                    end
                    phase = P_FSIZE;
                end
            end
            P_FSIZE: begin
                if (at == 7) phase = P_WAVE;
            end
            P_WAVE: begin
                if (at == 11) begin
                    if (shift_word != ID_WAVE) begin
                        finish_parse(wavhp_pkg::ST_NOT_WAVE, r);
                        return 1'b1;
                    end
                    open_chunk_id();
                end
            end
            P_CID: begin
                remaining = remaining - 32'd1;
                if (remaining == 0) begin
                    if (shift_word == ID_FMT) phase = P_SZ_FMT;
                    else if (shift_word == ID_DATA) phase = P_SZ_DATA;
                    else phase = P_SZ_OTHER;
                    remaining = 32'd4;
                end
            end
            P_SZ_FMT, P_SZ_DATA, P_SZ_OTHER: begin
                remaining = remaining - 32'd1;
                if (remaining == 0) begin
                    chunk_len = shift_word;
                    if (phase == P_SZ_FMT) begin
                        if (chunk_len < FMT_BODY) begin
                            finish_parse(wavhp_pkg::ST_FMT_SMALL, r);
                            return 1'b1;
                        end
                        fmt_body  = '0;
                        remaining = FMT_BODY;
                        phase     = P_FMT;
                    end else if (phase == P_SZ_DATA && fmt_done) begin
                        data_len = chunk_len;
                        data_pos = pos_ctr;
                        finish_parse(wavhp_pkg::ST_OK, r);
                        return 1'b1;
                    end else begin
                        skip_body(chunk_len);
                    end
                end
            end
            P_FMT: begin
                idx = 4'(FMT_BODY - remaining);
                fmt_body[idx*8 +: 8] = b;
                remaining = remaining - 32'd1;
                if (remaining == 0) begin
                    fmt_done = 1'b1;
                    skip_body(chunk_len - FMT_BODY);
                end
            end
            P_SKIP: begin
                remaining = remaining - 32'd1;
                if (remaining == 0) end_body();
            end
            default: begin
                open_chunk_id();
            end
        endcase
        if (is_last) begin
            if (phase == P_RIFF) finish_parse(wavhp_pkg::ST_NOT_RIFF, r);
            else if (phase == P_FSIZE || phase == P_WAVE)
                finish_parse(wavhp_pkg::ST_NOT_WAVE, r);
            else finish_parse(fmt_done ? wavhp_pkg::ST_NO_DATA : wavhp_pkg::ST_NO_FMT, r);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] MISMATCH %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        errors++;
    endtask

    // result check, then prediction for the byte taken at this edge
    always @(posedge aclk) begin : monitor
        header_t want, predicted;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_headers.size() == 0) begin
                    report_mismatch("result with none pending", 32'(m_tuser), '0);
                end else begin
                    want = pending_headers.pop_front();
                    results_seen++;
                    status_count[want.status]++;
                    if (m_tuser !== want.status)
                        report_mismatch("status", 32'(m_tuser), 32'(want.status));
                    if (m_tdata[15:0] !== want.channels)
                        report_mismatch("channel_count", 32'(m_tdata[15:0]), 32'(want.channels));
                    if (m_tdata[47:16] !== want.rate)
                        report_mismatch("sample_rate", m_tdata[47:16], want.rate);
                    if (m_tdata[79:48] !== want.byte_rate)
                        report_mismatch("bytes_per_second", m_tdata[79:48], want.byte_rate);
                    if (m_tdata[95:80] !== want.align)
                        report_mismatch("block_align", 32'(m_tdata[95:80]), 32'(want.align));
                    if (m_tdata[111:96] !== want.bits)
                        report_mismatch("sample_bits", 32'(m_tdata[111:96]), 32'(want.bits));
                    if (m_tdata[143:112] !== want.data_len)
                        report_mismatch("data_size", m_tdata[143:112], want.data_len);
                    if (m_tdata[175:144] !== want.data_pos)
                        report_mismatch("data_offset", m_tdata[175:144], want.data_pos);
                end
            end
            if (s_tvalid && s_tready) begin
                bytes_taken++;
                if (parse_header_byte(s_tdata, s_tuser, s_tlast, predicted))
                    pending_headers.push_back(predicted);
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
        else stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic void put_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++) file_bytes.push_back(w[8*i +: 8]);
    endfunction

    function automatic void put_random(input int n);
        repeat (n) file_bytes.push_back(8'($urandom));
    endfunction

    function automatic void put_chunk(input logic [31:0] id, input logic [31:0] len);
        put_word(id);
        put_word(len);
        put_random(int'(len) + int'(len[0]));
    endfunction

    // fill 1: all-zero fields, 2: all-ones fields, otherwise random
    function automatic void put_fmt(input logic [31:0] len, input int fill);
        put_word(ID_FMT);
        put_word(len);
        if (len < FMT_BODY) begin
            put_random(int'(len));
        end else begin
            repeat (16) file_bytes.push_back(fill == 1 ? 8'h00 : fill == 2 ? 8'hff : 8'($urandom));
            put_random(int'(len - FMT_BODY) + int'(len[0]));
        end
    endfunction

    function automatic void start_file();
        file_bytes = {};
        put_word(ID_RIFF);
        put_word($urandom);
        put_word(ID_WAVE);
    endfunction

    function automatic void build_wav(input logic [31:0] fmt_len, input int fill);
        start_file();
        repeat ($urandom_range(0, 2)) put_chunk($urandom, $urandom_range(0, 7));
        if ($urandom_range(0, 3) == 0) put_chunk(ID_DATA, $urandom_range(0, 7));
        put_fmt(fmt_len, fill);
        if ($urandom_range(0, 3) == 0) put_chunk($urandom, $urandom_range(0, 5));
        put_word(ID_DATA);
        put_word(fill == 1 ? 32'h0 : fill == 2 ? 32'hffff_ffff : 32'($urandom));
        put_random($urandom_range(0, 3));
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit is_first, input bit is_last);
        @(negedge aclk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= is_first;
        s_tlast  <= is_last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_file(input bit mark_first, input bit mark_end);
        for (int i = 0; i < file_bytes.size(); i++)
            send_byte(file_bytes[i], mark_first && i == 0,
                      mark_end && i == file_bytes.size() - 1);
        files_sent++;
    endtask

    task automatic wait_drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_headers.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic test_header_errors();
        // first file after reset carries no start marker
        file_bytes = {};
        put_word("XFIR");
        send_file(1'b0, 1'b0);
        // start and end marker on the same byte
        file_bytes = {8'hff};
        send_file(1'b1, 1'b1);
        // stream ends inside the file size
        file_bytes = {};
        put_word(ID_RIFF);
        file_bytes.push_back(8'h00);
        send_file(1'b1, 1'b1);
        file_bytes = {};
        put_word(ID_RIFF);
        put_word(32'hffff_ffff);
        put_word(ID_WAVE ^ 32'h0100_0000);
        send_file(1'b1, 1'b0);
        // bytes after a result are dropped, end marker included
        file_bytes = {8'h00, 8'hff};
        send_file(1'b0, 1'b1);
        wait_drain();
    endtask

    task automatic test_chunk_rules();
        start_file();
        put_fmt(32'd15, 0);
        send_file(1'b1, 1'b0);
        start_file();
        put_fmt(32'd0, 0);
        send_file(1'b1, 1'b0);
        // no fmt before the end, inside an oversized chunk
        start_file();
        put_word(ID_LIST);
        put_word(32'hffff_ffff);
        put_random(3);
        send_file(1'b1, 1'b1);
        // fmt body complete, end inside its skipped tail
        start_file();
        put_word(ID_FMT);
        put_word(32'hffff_ffff);
        put_random(18);
        send_file(1'b1, 1'b1);
        // data ahead of fmt is skipped; odd fmt with pad; all-ones fields
        start_file();
        put_chunk(ID_DATA, 32'd3);
        put_fmt(32'd17, 2);
        put_word(ID_DATA);
        put_word(32'hffff_ffff);
        send_file(1'b1, 1'b0);
        start_file();
        put_fmt(FMT_BODY, 1);
        put_word(ID_DATA);
        put_word(32'h0);
        put_random(2);
        send_file(1'b1, 1'b1);
        // restart part-way through a file
        build_wav(FMT_BODY, 0);
        while (file_bytes.size() > 20) void'(file_bytes.pop_back());
        send_file(1'b1, 1'b0);
        build_wav(FMT_BODY, 0);
        send_file(1'b1, 1'b0);
        wait_drain();
    endtask

    task automatic test_random_files();
        int          src_mix[4]  = '{0, 68, 0, 9};
        int          sink_mix[4] = '{0, 0, 68, 9};
        int          base_bytes, base_results, kind, fill, cut;
        bit          mark_end;
        logic [31:0] fmt_len;
        for (int p = 0; p < 4; p++) begin
            src_idle_pct   = src_mix[p];
            sink_stall_pct = sink_mix[p];
            base_bytes     = bytes_taken;
            base_results   = results_seen;
            while (bytes_taken - base_bytes < 90 || results_seen - base_results < 2) begin
                kind     = $urandom_range(0, 9);
                fill     = $urandom_range(0, 9);
                mark_end = ($urandom_range(0, 2) == 0);
                fmt_len  = FMT_BODY;
                if ($urandom_range(0, 3) == 0) fmt_len = FMT_BODY + $urandom_range(1, 5);
                case (kind)
                    0, 1, 2, 3, 4: begin
                        build_wav(fmt_len, fill);
                    end
                    5: begin
                        build_wav(fmt_len, fill);
                        cut = $urandom_range(0, 11);
                        file_bytes[cut] = file_bytes[cut] ^ (8'h01 << $urandom_range(0, 7));
                    end
                    6: begin
                        build_wav($urandom_range(0, 15), fill);
                    end
                    7: begin
                        build_wav(fmt_len, fill);
                        cut = $urandom_range(1, file_bytes.size() - 1);
                        while (file_bytes.size() > cut) void'(file_bytes.pop_back());
                        mark_end = 1'b1;
                    end
                    default: begin
                        file_bytes = {};
                        put_random($urandom_range(1, 8));
                    end
                endcase
                send_file($urandom_range(0, 15) != 0, mark_end);
            end
            wait_drain();
        end
        src_idle_pct   = 0;
        sink_stall_pct = 0;
    endtask

    // long result hold while requests keep coming; input must back up
    task automatic test_result_backpressure();
        hold_requests++;
        repeat (6) begin
            file_bytes = {};
            put_random(4);
            send_file(1'b1, 1'b0);
        end
        build_wav(FMT_BODY, 0);
        send_file(1'b1, 1'b0);
        wait_drain();
    endtask

    initial begin
        clear_parse();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_header_errors();
        test_chunk_rules();
        test_random_files();
        test_result_backpressure();
        $display("Run: %0d bytes in %0d files, %0d results: %0d ok, %0d bad RIFF, %0d bad WAVE,",
                 bytes_taken, files_sent, results_seen, status_count[wavhp_pkg::ST_OK],
                 status_count[wavhp_pkg::ST_NOT_RIFF], status_count[wavhp_pkg::ST_NOT_WAVE]);
        $display("  %0d short fmt, %0d no fmt, %0d no data; idle, sender, receiver, mixed stalls.",
                 status_count[wavhp_pkg::ST_FMT_SMALL], status_count[wavhp_pkg::ST_NO_FMT],
                 status_count[wavhp_pkg::ST_NO_DATA]);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/wavhp_pkg.sv
rtl/core/wav_header_parser.sv
test/testbench.sv
